// ===== rtl/core/prle_pkg.sv =====
// Shared types and constants for the palette run-length pixel decoder.
// No dependencies; every other file in rtl/core imports this package.
package prle_pkg;

    localparam int CODE_W      = 8;
    localparam int RUN_W       = 5;
    localparam int IDX_W       = 3;
    localparam int CHAN_W      = 8;
    localparam int COLOR_W     = 3 * CHAN_W;
    localparam int NUM_PALETTE = 8;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [RUN_W-1:0]   run_m1;
    } t_run_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

endpackage

// ===== rtl/core/prle_front.sv =====
// Front end: holds the palette registers, accepts code bytes and resolves
// each into a run entry for the queue. Depends on prle_pkg.
module prle_front
    import prle_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [IDX_W-1:0]     i_cfg_idx,
    input  logic [COLOR_W-1:0]   i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [CODE_W-1:0]    i_code,
    input  t_queue_status        i_qstat,
    output logic                 o_push,
    output t_run_entry           o_entry
);

    logic [COLOR_W-1:0] r_palette [NUM_PALETTE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PALETTE; i++) begin
                r_palette[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_palette[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign o_ready        = !i_qstat.full;
    assign o_push         = i_valid && !i_qstat.full;
    assign o_entry.color  = r_palette[i_code[IDX_W-1:0]];
    assign o_entry.run_m1 = i_code[CODE_W-1:IDX_W];

endmodule

// ===== rtl/core/prle_fifo.sv =====
// Short queue of run entries between the front and back ends.
// Depends on prle_pkg.
module prle_fifo
    import prle_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_run_entry    i_entry,
    input  logic          i_pop,
    output t_run_entry    o_entry,
    output t_queue_status o_stat
);

    t_run_entry        r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              push_ok;
    logic              pop_ok;

    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign push_ok      = i_push && !o_stat.full;
    assign pop_ok       = i_pop && !o_stat.empty;
    assign o_entry      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push_ok) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop_ok) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count exceeds depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == QCNT_W'(QDEPTH)) |-> (r_wptr == r_rptr))
        else $error("queue pointers disagree with count");
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.full && !pop_ok) |=> $stable(r_wptr))
        else $error("queue written while full");
`endif

endmodule

// ===== rtl/core/prle_back.sv =====
// Back end: takes run entries from the queue, tracks the pixel position,
// clips runs at the image end and drives the registered pixel output.
// Depends on prle_pkg.
module prle_back
    import prle_pkg::*;
#(
    parameter int IMAGE_PIXELS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_run_entry           i_entry,
    input  t_queue_status        i_qstat,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [COLOR_W-1:0]   o_data,
    output logic                 o_run_last,
    output logic                 o_image_last,
    output logic                 o_run_clipped
);

    localparam int POS_W = $clog2(IMAGE_PIXELS);
    localparam int REM_W = POS_W + 1;
    localparam int CMP_W = (REM_W > RUN_W + 1) ? REM_W : RUN_W + 1;

    t_back_state        r_state, n_state;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [RUN_W-1:0]   r_left_m1, n_left_m1;
    logic [COLOR_W-1:0] r_color, n_color;
    logic               r_clip, n_clip;
    logic               r_ovalid, n_ovalid;
    logic [COLOR_W-1:0] r_odata, n_odata;
    logic               r_orun_last, n_orun_last;
    logic               r_oimg_last, n_oimg_last;
    logic               r_oclip, n_oclip;

    logic [CMP_W-1:0]   remaining;
    logic [CMP_W-1:0]   run_len;
    logic               clipped;
    logic               img_end;
    logic               emit;

    assign remaining = CMP_W'(IMAGE_PIXELS) - CMP_W'(r_pos);
    assign run_len   = CMP_W'(i_entry.run_m1) + 1'b1;
    assign clipped   = run_len > remaining;
    assign img_end   = (r_pos == POS_W'(IMAGE_PIXELS - 1));
    assign emit      = (r_state == BK_RUN) && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pos    <= n_pos;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left_m1   <= n_left_m1;
        r_color     <= n_color;
        r_clip      <= n_clip;
        r_odata     <= n_odata;
        r_orun_last <= n_orun_last;
        r_oimg_last <= n_oimg_last;
        r_oclip     <= n_oclip;
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_left_m1   = r_left_m1;
        n_color     = r_color;
        n_clip      = r_clip;
        n_ovalid    = r_ovalid && !i_ready;
        n_odata     = r_odata;
        n_orun_last = r_orun_last;
        n_oimg_last = r_oimg_last;
        n_oclip     = r_oclip;
        o_pop       = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop     = 1'b1;
                    n_color   = i_entry.color;
                    n_clip    = clipped;
                    n_left_m1 = clipped ? RUN_W'(remaining - 1'b1) : i_entry.run_m1;
                    n_state   = BK_RUN;
                end
            end
            BK_RUN: begin
                if (emit) begin
                    n_ovalid    = 1'b1;
                    n_odata     = {r_color[CHAN_W-1:0], r_color[COLOR_W-1 -: CHAN_W],
                                   r_color[2*CHAN_W-1 -: CHAN_W]};
                    n_orun_last = (r_left_m1 == '0);
                    n_oimg_last = img_end;
                    n_oclip     = r_clip;
                    n_pos       = img_end ? '0 : r_pos + 1'b1;
                    n_left_m1   = r_left_m1 - 1'b1;
                    if (r_left_m1 == '0) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    assign o_valid       = r_ovalid;
    assign o_data        = r_odata;
    assign o_run_last    = r_orun_last;
    assign o_image_last  = r_oimg_last;
    assign o_run_clipped = r_oclip;

`ifndef NO_ASSERTIONS
    a_img_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oimg_last) |-> r_orun_last)
        else $error("image end inside a run");
    a_clip_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oclip && r_orun_last) |-> r_oimg_last)
        else $error("clipped run does not end at image end");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        REM_W'(r_pos) < REM_W'(IMAGE_PIXELS))
        else $error("pixel position out of range");
    a_pos_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && img_end) |=> (r_pos == '0))
        else $error("position did not wrap at image end");
`endif

endmodule

// ===== rtl/core/palette_rle_pixel_decoder.sv =====
// Palette run-length pixel decoder, top level: ties the front end, the run
// queue and the back end together. Depends on prle_pkg, prle_front,
// prle_fifo and prle_back.
//
// Each code byte (bits 7:3 run length minus one, bits 2:0 palette index)
// expands into 1 to 32 pixels, one per output word, green in the lowest
// byte of m_axis_tdata. The back end loads a run in its idle state and then
// emits one pixel per cycle in its run state while the output is not
// stalled. A two-entry queue lets code bytes be taken while a run is still
// being emitted. Palette writes take effect at the byte that is accepted
// after the write; there is no clearing pass.
module palette_rle_pixel_decoder
    import prle_pkg::*;
#(
    parameter int IMAGE_PIXELS = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [IDX_W-1:0]     i_cfg_idx,
    input  logic [COLOR_W-1:0]   i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [CODE_W-1:0]    s_axis_tdata,   // code_byte
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [COLOR_W-1:0]   m_axis_tdata,   // green_level, red_level, blue_level
    output logic                 m_axis_tlast,   // run_last
    output logic [1:0]           m_axis_tuser    // image_last, run_clipped
);

    t_queue_status qstat;
    t_run_entry    push_entry;
    t_run_entry    pop_entry;
    logic          push;
    logic          pop;
    logic          img_last;
    logic          clip;

    prle_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_code     (s_axis_tdata),
        .i_qstat    (qstat),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    prle_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (pop_entry),
        .o_stat  (qstat)
    );

    prle_back #(
        .IMAGE_PIXELS (IMAGE_PIXELS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (pop_entry),
        .i_qstat       (qstat),
        .o_pop         (pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_data        (m_axis_tdata),
        .o_run_last    (m_axis_tlast),
        .o_image_last  (img_last),
        .o_run_clipped (clip)
    );

    assign m_axis_tuser = {clip, img_last};

endmodule
